// ----- rtl/prpa_pkg.sv -----
// Shared types and constants for the relocation patch applier.
`timescale 1ns / 1ps
`default_nettype none

package prpa_pkg;

    localparam logic [7:0] CMD_ADDR32      = 8'd1;
    localparam logic [7:0] CMD_ADDR16_LO   = 8'd4;
    localparam logic [7:0] CMD_ADDR16_HI   = 8'd5;
    localparam logic [7:0] CMD_ADDR16_HA   = 8'd6;
    localparam logic [7:0] CMD_REL24       = 8'd10;
    localparam logic [7:0] CMD_WRITE32     = 8'd32;
    localparam logic [7:0] CMD_WRITE16     = 8'd33;
    localparam logic [7:0] CMD_WRITE8      = 8'd34;
    localparam logic [7:0] CMD_COND_PTR    = 8'd35;
    localparam logic [7:0] CMD_COND32      = 8'd36;
    localparam logic [7:0] CMD_COND16      = 8'd37;
    localparam logic [7:0] CMD_COND8       = 8'd38;
    localparam logic [7:0] CMD_B           = 8'd64;
    localparam logic [7:0] CMD_BL          = 8'd65;

    localparam logic [1:0] SZ_BYTE = 2'd0;
    localparam logic [1:0] SZ_HALF = 2'd1;
    localparam logic [1:0] SZ_WORD = 2'd2;

    localparam logic [1:0] ST_APPLIED  = 2'd0;
    localparam logic [1:0] ST_MISMATCH = 2'd1;
    localparam logic [1:0] ST_SKIPPED  = 2'd2;
    localparam logic [1:0] ST_UNKNOWN  = 2'd3;

    localparam logic [1:0] REG_TEXT_BASE     = 2'd0;
    localparam logic [1:0] REG_MAIN_LOAD     = 2'd1;
    localparam logic [1:0] REG_SPLIT_ADDRESS = 2'd2;

    localparam logic [23:0] ABS_MARKER       = 24'hFFFFFE;
    localparam logic [31:0] SPLIT_RESET      = 32'h80510238;
    localparam logic [31:0] BRANCH_KEEP_MASK = 32'hFC000003;
    localparam logic [31:0] BRANCH_DISP_MASK = 32'h03FFFFFC;
    localparam logic [31:0] BRANCH_B_OP      = 32'h48000000;
    localparam logic [31:0] BRANCH_BL_OP     = 32'h48000001;

    typedef struct packed {
        logic [7:0]  cmd;
        logic        is_abs;
        logic [31:0] addr;
        logic [31:0] op_res;
        logic [31:0] val;
        logic [31:0] mem;
        logic        eq32;
        logic        eq16;
        logic        eq8;
    } front_t;

endpackage

`default_nettype wire

// ----- rtl/prpa_resolve.sv -----
// First-stage address and operand resolution with condition compares.
`timescale 1ns / 1ps
`default_nettype none

module prpa_resolve (
    input  wire logic [7:0]      req_type,
    input  wire logic [23:0]     patch_offset,
    input  wire logic [31:0]     absolute_address,
    input  wire logic [31:0]     operand_value,
    input  wire logic [31:0]     expected_original,
    input  wire logic [31:0]     current_memory,
    input  wire logic [31:0]     text_base,
    output prpa_pkg::front_t     front
);

    logic is_abs;

    assign is_abs = (patch_offset == prpa_pkg::ABS_MARKER);

    always_comb
    begin
        front.cmd    = req_type;
        front.is_abs = is_abs;
        front.addr   = is_abs ? absolute_address : (text_base + {8'd0, patch_offset});
        front.op_res = operand_value[31] ? operand_value : (text_base + operand_value);
        front.val    = operand_value;
        front.mem    = current_memory;
        front.eq32   = (current_memory == expected_original);
        front.eq16   = (current_memory[31:16] == expected_original[15:0]);
        front.eq8    = (current_memory[31:24] == expected_original[7:0]);
    end

endmodule

`default_nettype wire

// ----- rtl/powerpc_reloc_patch_applier.sv -----
// Top level: three-stage relocation patch pipeline with stream ports.
//
// One patch command enters per transfer on the s_ channel: s_tuser holds the
// command code, s_tdata the offset, absolute address, operand, expected
// original value and the big-endian memory word at the target. Each command
// yields exactly one write request on the m_ channel, in order.
// Configuration (text_base, main_load, split_address) is written through
// cfg_we / cfg_index / cfg_wdata while no command is in flight.
// A command's result is presented on the m_ channel once it has passed the
// stage 1, stage 2 and output registers in turn; a stall can hold it.
// Throughput: one command per cycle while m_tready holds no result back; the
// three register stages (address and operand add, region compare and branch
// subtract, result select) each hold one command.
// Reset clears all stage valid bits and restores the register defaults.
// When the receiver holds m_tready low, the output stage holds its result
// and back-pressure reaches s_tready only as stages fill, so nothing is
// lost or repeated.
`timescale 1ns / 1ps
`default_nettype none

module powerpc_reloc_patch_applier (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         cfg_we,
    input  wire logic [1:0]   cfg_index,
    input  wire logic [31:0]  cfg_wdata,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // patch_offset[23:0], absolute_address[55:24], operand_value[87:56],
    // expected_original[119:88], current_memory[151:120]
    input  wire logic [151:0] s_tdata,
    // req_type[7:0]
    input  wire logic [7:0]   s_tuser,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // write_enable[0], write_address[32:1], write_size[34:33],
    // write_data[66:35], invalidate[67], zero[71:68]
    output logic [71:0]       m_tdata,
    // status[1:0]
    output logic [1:0]        m_tuser
);

    logic [31:0] text_base_reg;
    logic        main_load_reg;
    logic [31:0] split_address_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            text_base_reg     <= 32'd0;
            main_load_reg     <= 1'b1;
            split_address_reg <= prpa_pkg::SPLIT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                prpa_pkg::REG_TEXT_BASE:     text_base_reg     <= cfg_wdata;
                prpa_pkg::REG_MAIN_LOAD:     main_load_reg     <= cfg_wdata[0];
                prpa_pkg::REG_SPLIT_ADDRESS: split_address_reg <= cfg_wdata;
                default:                     ;
            endcase
        end
    end

    // Stage 1: resolve target address and operand.
    prpa_pkg::front_t front;
    prpa_pkg::front_t s1_reg;
    logic             s1_valid_reg;

    prpa_resolve u_resolve (
        .req_type          (s_tuser),
        .patch_offset      (s_tdata[23:0]),
        .absolute_address  (s_tdata[55:24]),
        .operand_value     (s_tdata[87:56]),
        .expected_original (s_tdata[119:88]),
        .current_memory    (s_tdata[151:120]),
        .text_base         (text_base_reg),
        .front             (front)
    );

    // Stage 2 payload.
    logic        s2_valid_reg;
    logic [7:0]  s2_cmd_reg;
    logic [31:0] s2_addr_reg;
    logic [31:0] s2_op_res_reg;
    logic [31:0] s2_val_reg;
    logic [31:0] s2_mem_reg;
    logic        s2_eq32_reg;
    logic        s2_eq16_reg;
    logic        s2_eq8_reg;
    logic        s2_skip_reg;
    logic [31:0] s2_delta_reg;
    logic [15:0] s2_ha_reg;

    // Stage 3 payload (output register).
    logic        s3_valid_reg;
    logic        s3_we_reg;
    logic [31:0] s3_addr_reg;
    logic [1:0]  s3_size_reg;
    logic [31:0] s3_data_reg;
    logic        s3_inval_reg;
    logic [1:0]  s3_status_reg;

    logic ready3;
    logic ready2;
    logic ready1;

    assign ready3   = !s3_valid_reg || m_tready;
    assign ready2   = !s2_valid_reg || ready3;
    assign ready1   = !s1_valid_reg || ready2;
    assign s_tready = ready1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            if (ready1)
            begin
                s1_valid_reg <= s_tvalid;
            end
            if (ready2)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (ready3)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready1 && s_tvalid)
        begin
            s1_reg <= front;
        end
    end

    logic        skip_next;
    logic [31:0] delta_next;
    logic [15:0] ha_next;

    always_comb
    begin
        if (s1_reg.is_abs)
        begin
            skip_next = main_load_reg ? (s1_reg.addr >= split_address_reg)
                                      : (s1_reg.addr < split_address_reg);
        end
        else
        begin
            skip_next = !main_load_reg;
        end
        delta_next = s1_reg.op_res - s1_reg.addr;
        ha_next    = s1_reg.op_res[31:16] + {15'd0, s1_reg.op_res[15]};
    end

    always_ff @(posedge clk)
    begin
        if (ready2 && s1_valid_reg)
        begin
            s2_cmd_reg    <= s1_reg.cmd;
            s2_addr_reg   <= s1_reg.addr;
            s2_op_res_reg <= s1_reg.op_res;
            s2_val_reg    <= s1_reg.val;
            s2_mem_reg    <= s1_reg.mem;
            s2_eq32_reg   <= s1_reg.eq32;
            s2_eq16_reg   <= s1_reg.eq16;
            s2_eq8_reg    <= s1_reg.eq8;
            s2_skip_reg   <= skip_next;
            s2_delta_reg  <= delta_next;
            s2_ha_reg     <= ha_next;
        end
    end

    logic        we_next;
    logic [1:0]  size_next;
    logic [31:0] data_next;
    logic        inval_next;
    logic [1:0]  status_next;
    logic [31:0] disp;

    assign disp = s2_delta_reg & prpa_pkg::BRANCH_DISP_MASK;

    always_comb
    begin
        we_next     = 1'b0;
        size_next   = prpa_pkg::SZ_BYTE;
        data_next   = 32'd0;
        inval_next  = 1'b1;
        status_next = prpa_pkg::ST_APPLIED;
        if (s2_skip_reg)
        begin
            inval_next  = 1'b0;
            status_next = prpa_pkg::ST_SKIPPED;
        end
        else
        begin
            unique case (s2_cmd_reg)
                prpa_pkg::CMD_ADDR32:
                begin
                    we_next   = 1'b1;
                    size_next = prpa_pkg::SZ_WORD;
                    data_next = s2_op_res_reg;
                end
                prpa_pkg::CMD_ADDR16_LO:
                begin
                    we_next   = 1'b1;
                    size_next = prpa_pkg::SZ_HALF;
                    data_next = {16'd0, s2_op_res_reg[15:0]};
                end
                prpa_pkg::CMD_ADDR16_HI:
                begin
                    we_next   = 1'b1;
                    size_next = prpa_pkg::SZ_HALF;
                    data_next = {16'd0, s2_op_res_reg[31:16]};
                end
                prpa_pkg::CMD_ADDR16_HA:
                begin
                    we_next   = 1'b1;
                    size_next = prpa_pkg::SZ_HALF;
                    data_next = {16'd0, s2_ha_reg};
                end
                prpa_pkg::CMD_REL24:
                begin
                    we_next   = 1'b1;
                    size_next = prpa_pkg::SZ_WORD;
                    data_next = (s2_mem_reg & prpa_pkg::BRANCH_KEEP_MASK) | disp;
                end
                prpa_pkg::CMD_WRITE32:
                begin
                    we_next   = 1'b1;
                    size_next = prpa_pkg::SZ_WORD;
                    data_next = s2_val_reg;
                end
                prpa_pkg::CMD_WRITE16:
                begin
                    we_next   = 1'b1;
                    size_next = prpa_pkg::SZ_HALF;
                    data_next = {16'd0, s2_val_reg[15:0]};
                end
                prpa_pkg::CMD_WRITE8:
                begin
                    we_next   = 1'b1;
                    size_next = prpa_pkg::SZ_BYTE;
                    data_next = {24'd0, s2_val_reg[7:0]};
                end
                prpa_pkg::CMD_COND_PTR, prpa_pkg::CMD_COND32:
                begin
                    size_next = prpa_pkg::SZ_WORD;
                    if (s2_eq32_reg)
                    begin
                        we_next   = 1'b1;
                        data_next = (s2_cmd_reg == prpa_pkg::CMD_COND_PTR) ? s2_op_res_reg
                                                                           : s2_val_reg;
                    end
                    else
                    begin
                        status_next = prpa_pkg::ST_MISMATCH;
                    end
                end
                prpa_pkg::CMD_COND16:
                begin
                    size_next = prpa_pkg::SZ_HALF;
                    if (s2_eq16_reg)
                    begin
                        we_next   = 1'b1;
                        data_next = {16'd0, s2_val_reg[15:0]};
                    end
                    else
                    begin
                        status_next = prpa_pkg::ST_MISMATCH;
                    end
                end
                prpa_pkg::CMD_COND8:
                begin
                    size_next = prpa_pkg::SZ_BYTE;
                    if (s2_eq8_reg)
                    begin
                        we_next   = 1'b1;
                        data_next = {24'd0, s2_val_reg[7:0]};
                    end
                    else
                    begin
                        status_next = prpa_pkg::ST_MISMATCH;
                    end
                end
                prpa_pkg::CMD_B:
                begin
                    we_next   = 1'b1;
                    size_next = prpa_pkg::SZ_WORD;
                    data_next = (prpa_pkg::BRANCH_B_OP & prpa_pkg::BRANCH_KEEP_MASK) | disp;
                end
                prpa_pkg::CMD_BL:
                begin
                    we_next   = 1'b1;
                    size_next = prpa_pkg::SZ_WORD;
                    data_next = (prpa_pkg::BRANCH_BL_OP & prpa_pkg::BRANCH_KEEP_MASK) | disp;
                end
                default:
                begin
                    status_next = prpa_pkg::ST_UNKNOWN;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready3 && s2_valid_reg)
        begin
            s3_we_reg     <= we_next;
            s3_addr_reg   <= s2_addr_reg;
            s3_size_reg   <= size_next;
            s3_data_reg   <= data_next;
            s3_inval_reg  <= inval_next;
            s3_status_reg <= status_next;
        end
    end

    assign m_tvalid = s3_valid_reg;
    assign m_tdata  = {4'd0, s3_inval_reg, s3_data_reg, s3_size_reg, s3_addr_reg, s3_we_reg};
    assign m_tuser  = s3_status_reg;

`ifndef NO_ASSERTIONS
    a_skip_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        (s3_valid_reg && s3_status_reg == prpa_pkg::ST_SKIPPED)
            |-> (!s3_we_reg && !s3_inval_reg && s3_data_reg == 32'd0))
        else $error("skipped command carries a write");

    a_applied_writes: assert property (@(posedge clk) disable iff (!rst_n)
        (s3_valid_reg && s3_status_reg == prpa_pkg::ST_APPLIED)
            |-> (s3_we_reg && s3_inval_reg))
        else $error("applied command without write");

    a_mismatch_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        (s3_valid_reg && s3_status_reg == prpa_pkg::ST_MISMATCH)
            |-> (!s3_we_reg && s3_inval_reg && s3_data_reg == 32'd0))
        else $error("mismatch command carries a write");

    a_stage2_advances: assert property (@(posedge clk) disable iff (!rst_n)
        (s2_valid_reg && ready3) |=> s3_valid_reg)
        else $error("stage 2 item dropped");

    a_stage1_held: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !ready2) |=> s1_valid_reg)
        else $error("stalled stage 1 item lost");
`endif

endmodule

`default_nettype wire
